// File: sv/word_lzw_encoder_top_assert.svh
// Assertion macros for the word LZW encoder.
// Used by word_lzw_encoder_top; no other dependencies.
`ifndef WORD_LZW_ENCODER_TOP_ASSERT_SVH
`define WORD_LZW_ENCODER_TOP_ASSERT_SVH

// Check that a condition implies a property in the same cycle.
`define WLZW_ASSERT_NOW(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);

// Check that a condition implies a property in the next cycle.
`define WLZW_ASSERT_NEXT(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

// File: sv/wlzw_pkg.sv
// Shared types, constants and the slot hash of the word LZW encoder.
// No dependencies; imported by every module of the block.
package wlzw_pkg;

    localparam int SYMBOLS  = 65536;
    localparam int PHRASES  = 4096;
    localparam int SYM_W    = 16;
    localparam int CODE_W   = 30;
    localparam int PHRASE_W = $clog2(PHRASES);
    localparam int NEXT_W   = PHRASE_W + 1;
    localparam int SLOT_W   = PHRASE_W + 1;
    localparam int SLOTS    = 2 * PHRASES;

    localparam logic [CODE_W-1:0] BASE_CODE = CODE_W'(64'd1000000000);
    localparam logic [SYM_W-1:0]  SYM_MASK  = SYM_W'(SYMBOLS - 1);

    // Multipliers of the slot hash, reduced to the slot index width
    localparam logic [SLOT_W-1:0] HASH_CODE_MUL = SLOT_W'(64'd2654435761);
    localparam logic [SLOT_W-1:0] HASH_SYM_MUL  = SLOT_W'(64'd40503);

    // Output queue
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = FIFO_AW + 1;

    typedef struct packed {
        logic [SYM_W-1:0] symbol;
        logic             last_in;
    } t_in_word;

    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic              last_out;
    } t_out_word;

    // One hash slot: key (phrase code, symbol) and the phrase number it maps to
    typedef struct packed {
        logic                valid;
        logic [CODE_W-1:0]   code;
        logic [SYM_W-1:0]    symbol;
        logic [PHRASE_W-1:0] phrase;
    } t_slot;

    typedef struct packed {
        logic full;
        logic room2;
    } t_fifo_status;

    // Home slot of a key: low bits of code * A + symbol * B
    function automatic logic [SLOT_W-1:0] slot_hash(input logic [CODE_W-1:0] code,
                                                     input logic [SYM_W-1:0]  sym);
        logic [SLOT_W-1:0] prod_code;
        logic [SLOT_W-1:0] prod_sym;
        prod_code = SLOT_W'(code) * HASH_CODE_MUL;
        prod_sym  = SLOT_W'(sym) * HASH_SYM_MUL;
        return prod_code + prod_sym;
    endfunction

endpackage

// File: sv/wlzw_slot_ram.sv
// Single-port synchronous slot memory of the phrase hash table.
// Depends on wlzw_pkg for the slot type and depth.
module wlzw_slot_ram (
    input  logic                      i_clk,
    input  logic                      i_we,
    input  logic [wlzw_pkg::SLOT_W-1:0] i_addr,
    input  wlzw_pkg::t_slot           i_wdata,
    output wlzw_pkg::t_slot           o_rdata
);
    import wlzw_pkg::*;

    t_slot r_mem [SLOTS];
    t_slot r_rdata;

    // Write, and return the old contents of the address as a registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: sv/wlzw_out_fifo.sv
// Small output queue of code words between the encoder core and the output port.
// Depends on wlzw_pkg for the word type and queue depth.
module wlzw_out_fifo (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  wlzw_pkg::t_out_word   i_push_data,
    output wlzw_pkg::t_fifo_status o_status,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output wlzw_pkg::t_out_word   o_out_data
);
    import wlzw_pkg::*;

    t_out_word          r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_wr_ptr;
    logic [FIFO_AW-1:0] r_rd_ptr;
    logic [FIFO_CW-1:0] r_count;
    logic [FIFO_AW-1:0] n_wr_ptr;
    logic [FIFO_AW-1:0] n_rd_ptr;
    logic [FIFO_CW-1:0] n_count;
    logic               w_pop;

    assign w_pop       = o_out_valid && i_out_ready;
    assign o_out_valid = (r_count != '0);
    assign o_out_data  = r_mem[r_rd_ptr];

    assign o_status.full  = (r_count == FIFO_CW'(FIFO_DEPTH));
    assign o_status.room2 = (r_count <= FIFO_CW'(FIFO_DEPTH - 2));

    // Advance pointers and occupancy
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = r_wr_ptr + 1'b1;
        end
        if (w_pop) begin
            n_rd_ptr = r_rd_ptr + 1'b1;
        end
        if (i_push && !w_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && w_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Hold queued words
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

endmodule

// File: sv/word_lzw_encoder_top.sv
// LZW encoder over 16-bit word ids: the phrase lookup of a symbol passes through the
// probe and check states once for each slot of linear probing, in the single-port
// slot memory's read-compare-write loop; the first symbol of a stream needs no
// lookup, and a last symbol adds a flush state. A word is taken only while the
// output queue has room for two code words, so a stalled receiver holds the input
// off. After reset and after every last symbol the hash table is cleared in a pass
// over all 8192 slots, one slot a cycle, during which no word is accepted.
// Depends on wlzw_pkg, wlzw_slot_ram, wlzw_out_fifo and the assertion macro header.
module word_lzw_encoder_top (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  wlzw_pkg::t_in_word  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output wlzw_pkg::t_out_word o_out_data
);
    import wlzw_pkg::*;

    `include "word_lzw_encoder_top_assert.svh"

    localparam logic [2:0] S_WIPE  = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_PROBE = 3'd2;
    localparam logic [2:0] S_CHECK = 3'd3;
    localparam logic [2:0] S_FLUSH = 3'd4;

    logic [2:0]        r_state;
    logic [2:0]        n_state;
    logic [SLOT_W-1:0] r_addr;
    logic [SLOT_W-1:0] n_addr;
    logic [CODE_W-1:0] r_cur_code;
    logic [CODE_W-1:0] n_cur_code;
    logic              r_phrase_open;
    logic              n_phrase_open;
    logic [NEXT_W-1:0] r_next_phrase;
    logic [NEXT_W-1:0] n_next_phrase;
    logic [SYM_W-1:0]  r_symbol;
    logic [SYM_W-1:0]  n_symbol;
    logic              r_last;
    logic              n_last;

    logic              w_accept;
    logic [SYM_W-1:0]  w_in_sym;
    logic              w_we;
    t_slot             w_wdata;
    t_slot             w_rdata;
    logic              w_hit;
    logic              w_push;
    t_out_word         w_push_data;
    t_fifo_status      w_fifo_status;

    assign w_in_sym   = i_in_data.symbol & SYM_MASK;
    assign o_in_ready = (r_state == S_IDLE) && w_fifo_status.room2;
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_hit      = w_rdata.valid && (w_rdata.code == r_cur_code)
                        && (w_rdata.symbol == r_symbol);

    // Sequence one word: hash, probe, compare, insert, flush, clear
    always_comb begin
        n_state       = r_state;
        n_addr        = r_addr;
        n_cur_code    = r_cur_code;
        n_phrase_open = r_phrase_open;
        n_next_phrase = r_next_phrase;
        n_symbol      = r_symbol;
        n_last        = r_last;
        w_we          = 1'b0;
        w_wdata       = '0;
        w_push        = 1'b0;
        w_push_data   = '0;
        unique case (r_state)
            S_WIPE: begin
                w_we   = 1'b1;
                n_addr = r_addr + 1'b1;
                if (r_addr == SLOT_W'(SLOTS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_accept) begin
                    n_symbol = w_in_sym;
                    n_last   = i_in_data.last_in;
                    if (!r_phrase_open) begin
                        n_cur_code    = BASE_CODE + CODE_W'(w_in_sym);
                        n_phrase_open = 1'b1;
                        if (i_in_data.last_in) begin
                            n_state = S_FLUSH;
                        end
                    end else begin
                        n_addr  = slot_hash(r_cur_code, w_in_sym);
                        n_state = S_PROBE;
                    end
                end
            end
            S_PROBE: begin
                n_state = S_CHECK;
            end
            S_CHECK: begin
                if (w_hit) begin
                    n_cur_code = CODE_W'(w_rdata.phrase);
                    n_state    = r_last ? S_FLUSH : S_IDLE;
                end else if (w_rdata.valid) begin
                    n_addr  = r_addr + 1'b1;
                    n_state = S_PROBE;
                end else begin
                    // Miss: emit the phrase, store the extension while room remains
                    w_push               = 1'b1;
                    w_push_data.code     = r_cur_code;
                    w_push_data.last_out = 1'b0;
                    if (r_next_phrase < NEXT_W'(PHRASES)) begin
                        w_we           = 1'b1;
                        w_wdata.valid  = 1'b1;
                        w_wdata.code   = r_cur_code;
                        w_wdata.symbol = r_symbol;
                        w_wdata.phrase = r_next_phrase[PHRASE_W-1:0];
                        n_next_phrase  = r_next_phrase + 1'b1;
                    end
                    n_cur_code = BASE_CODE + CODE_W'(r_symbol);
                    n_state    = r_last ? S_FLUSH : S_IDLE;
                end
            end
            S_FLUSH: begin
                w_push               = 1'b1;
                w_push_data.code     = r_cur_code;
                w_push_data.last_out = 1'b1;
                n_cur_code           = '0;
                n_phrase_open        = 1'b0;
                n_next_phrase        = '0;
                n_addr               = '0;
                n_state              = S_WIPE;
            end
            default: begin
                n_state = S_WIPE;
                n_addr  = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_WIPE;
            r_addr        <= '0;
            r_cur_code    <= '0;
            r_phrase_open <= 1'b0;
            r_next_phrase <= '0;
        end else begin
            r_state       <= n_state;
            r_addr        <= n_addr;
            r_cur_code    <= n_cur_code;
            r_phrase_open <= n_phrase_open;
            r_next_phrase <= n_next_phrase;
        end
    end

    // Hold the word under work
    always_ff @(posedge i_clk) begin
        r_symbol <= n_symbol;
        r_last   <= n_last;
    end

    wlzw_slot_ram u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_addr  (r_addr),
        .i_wdata (w_wdata),
        .o_rdata (w_rdata)
    );

    wlzw_out_fifo u_out_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .i_push_data (w_push_data),
        .o_status    (w_fifo_status),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    // A flush leaves a clean, closed phrase state and starts the clearing pass
    `WLZW_ASSERT_NEXT(a_flush_clears, i_clk, i_rst_n, r_state == S_FLUSH, (r_state == S_WIPE) && !r_phrase_open && (r_next_phrase == '0), "flush did not clear the phrase state")
    // The phrase counter never runs past the dictionary size
    `WLZW_ASSERT_NOW(a_phrase_bound, i_clk, i_rst_n, 1'b1, r_next_phrase <= NEXT_W'(PHRASES), "phrase counter exceeds dictionary size")
    // The room check at acceptance keeps the output queue from overflowing
    `WLZW_ASSERT_NOW(a_no_overflow, i_clk, i_rst_n, w_push, !w_fifo_status.full, "code word pushed into full output queue")

endmodule

// File: tb/word_lzw_encoder_top_test.sv
// Self-checking testbench for word_lzw_encoder_top: directed table, then random streams.
// Depends on wlzw_pkg and the encoder RTL; predicts every code and compares in order.
module word_lzw_encoder_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    import wlzw_pkg::*;

    // Longest quiet stretch allowed: covers a table clear over all 8192 slots, plus stalls and probing
    localparam int QUIET_LIMIT = 50000;
    localparam int DIR_ROWS    = 17;

    // One row of the directed table; typed rows carry their codes, others use the predictor
    typedef struct packed {
        logic [SYM_W-1:0]  symbol;
        logic              last_in;
        logic              typed;
        logic [1:0]        n_exp;
        logic [CODE_W-1:0] c0;
        logic              l0;
        logic [CODE_W-1:0] c1;
        logic              l1;
    } t_dir_row;

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    logic      o_in_ready;
    t_in_word  i_in_data   = '0;
    logic      o_out_valid;
    logic      i_out_ready = 1'b0;
    t_out_word o_out_data;

    // Encoder state as seen by the predictor
    logic [CODE_W-1:0] enc_code;
    logic              enc_open;
    int                enc_count;
    logic [CODE_W-1:0] phrase_of [logic [CODE_W+SYM_W-1:0]];

    t_out_word pending_codes [$];
    t_dir_row  dir_rows [DIR_ROWS];
    int        n_errors       = 0;
    int        quiet_cycles   = 0;
    int        send_idle_pct  = 0;
    int        recv_stall_pct = 0;

    word_lzw_encoder_top DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Advance the phrase by one symbol; return the number of codes it emits
    function automatic int encode_symbol(input t_in_word w, output t_out_word r0,
                                         output t_out_word r1);
        logic [CODE_W+SYM_W-1:0] key;
        int                      n_res;
        n_res = 0;
        r0    = '0;
        r1    = '0;
        if (!enc_open) begin
            enc_code = BASE_CODE + CODE_W'(w.symbol);
            enc_open = 1'b1;
        end else begin
            key = {enc_code, w.symbol};
            if (phrase_of.exists(key)) begin
                enc_code = phrase_of[key];
            end else begin
                r0    = '{code: enc_code, last_out: 1'b0};
                n_res = 1;
                // Store the extended phrase while there is room
                if (enc_count < PHRASES) begin
                    phrase_of[key] = CODE_W'(enc_count);
                    enc_count++;
                end
                enc_code = BASE_CODE + CODE_W'(w.symbol);
            end
        end
        // Flush the open phrase and start a fresh stream
        if (w.last_in) begin
            if (n_res == 0) r0 = '{code: enc_code, last_out: 1'b1};
            else            r1 = '{code: enc_code, last_out: 1'b1};
            n_res++;
            phrase_of.delete();
            enc_count = 0;
            enc_code  = '0;
            enc_open  = 1'b0;
        end
        return n_res;
    endfunction

    // Offer one word, wait for it to be taken, then queue the codes it should produce
    task automatic feed_symbol(input t_in_word w, input logic typed, input int n_typed,
                               input t_out_word t0, input t_out_word t1);
        bit        gap;
        int        n_res;
        t_out_word r0;
        t_out_word r1;
        gap = ($urandom_range(99) < send_idle_pct);
        if (gap) begin
            i_in_valid <= 1'b0;
            while (gap) begin
                @(posedge i_clk);
                gap = ($urandom_range(99) < send_idle_pct);
            end
        end
        i_in_valid <= 1'b1;
        i_in_data  <= w;
        do @(posedge i_clk); while (o_in_ready !== 1'b1);
        n_res = encode_symbol(w, r0, r1);
        if (typed) begin
            n_res = n_typed;
            r0    = t0;
            r1    = t1;
        end
        if (n_res > 0) pending_codes = {pending_codes, r0};
        if (n_res > 1) pending_codes = {pending_codes, r1};
    endtask

    // One stream: a leading run of arbitrary ids, then mostly a small alphabet with noise
    task automatic play_stream(input int len, input int alpha_n, input int rand_head);
        logic [SYM_W-1:0] alpha [16];
        t_in_word         w;
        int               r;
        for (int k = 0; k < alpha_n; k++) begin
            r = $urandom_range(9);
            alpha[k] = (r == 0) ? '0 : (r == 1) ? '1 : SYM_W'($urandom_range(65535));
        end
        for (int k = 0; k < len; k++) begin
            if (alpha_n == 0 || k < rand_head || $urandom_range(9) == 0)
                w.symbol = SYM_W'($urandom_range(65535));
            else
                w.symbol = alpha[$urandom_range(alpha_n - 1)];
            w.last_in = (k == len - 1);
            feed_symbol(w, 1'b0, 0, '0, '0);
        end
    endtask

    // Mix of lone symbols, short arbitrary streams and longer repetitive ones
    task automatic random_streams(input int budget);
        int done;
        int len;
        int kind;
        done = 0;
        while (done < budget) begin
            kind = $urandom_range(9);
            if (kind == 0) begin
                len = 1;
                play_stream(len, 0, 0);
            end else if (kind <= 2) begin
                len = $urandom_range(20, 2);
                play_stream(len, 0, 0);
            end else begin
                len = $urandom_range(60, 8);
                play_stream(len, $urandom_range(6, 1), 0);
            end
            done += len;
        end
    endtask

    // Receiver: stall at the rate of the current phase
    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Compare every accepted word with the oldest pending code
    always @(posedge i_clk) begin
        t_out_word want;
        if (i_rst_n && o_out_valid === 1'b1 && i_out_ready) begin
            if (pending_codes.size() == 0) begin
                $error("unexpected word: code %0d last_out %0b",
                       o_out_data.code, o_out_data.last_out);
                n_errors++;
            end else begin
                want = pending_codes.pop_front();
                if (o_out_data.code !== want.code) begin
                    $error("code mismatch: expected %0d, got %0d", want.code, o_out_data.code);
                    n_errors++;
                end
                if (o_out_data.last_out !== want.last_out) begin
                    $error("last_out mismatch: expected %0b, got %0b",
                           want.last_out, o_out_data.last_out);
                    n_errors++;
                end
            end
        end
    end

    // Watchdog: end the run if no word moves on either side for too long
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready === 1'b1) || (o_out_valid === 1'b1 && i_out_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == QUIET_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        t_dir_row  row;
        t_in_word  w;
        int        send_pcts [4];
        int        recv_pcts [4];
        send_pcts = '{0, 52, 0, 31};
        recv_pcts = '{0, 0, 52, 31};
        enc_code  = '0;
        enc_open  = 1'b0;
        enc_count = 0;

        // Lone symbols at both extremes, a run of one id, extreme ids alternating,
        // two codes on a last miss, and a last symbol that extends the phrase
        dir_rows = '{
            '{16'h0000, 1'b1, 1'b1, 2'd1, BASE_CODE, 1'b1, '0, 1'b0},
            '{16'hFFFF, 1'b1, 1'b1, 2'd1, BASE_CODE + CODE_W'(16'hFFFF), 1'b1, '0, 1'b0},
            '{16'd5, 1'b0, 1'b1, 2'd0, '0, 1'b0, '0, 1'b0},
            '{16'd5, 1'b0, 1'b1, 2'd1, BASE_CODE + CODE_W'(5), 1'b0, '0, 1'b0},
            '{16'd5, 1'b0, 1'b1, 2'd0, '0, 1'b0, '0, 1'b0},
            '{16'd5, 1'b1, 1'b1, 2'd2, '0, 1'b0, BASE_CODE + CODE_W'(5), 1'b1},
            '{16'hFFFF, 1'b0, 1'b1, 2'd0, '0, 1'b0, '0, 1'b0},
            '{16'h0000, 1'b0, 1'b1, 2'd1, BASE_CODE + CODE_W'(16'hFFFF), 1'b0, '0, 1'b0},
            '{16'hFFFF, 1'b0, 1'b1, 2'd1, BASE_CODE, 1'b0, '0, 1'b0},
            '{16'h0000, 1'b0, 1'b0, 2'd0, '0, 1'b0, '0, 1'b0},
            '{16'hFFFF, 1'b0, 1'b0, 2'd0, '0, 1'b0, '0, 1'b0},
            '{16'h0000, 1'b0, 1'b0, 2'd0, '0, 1'b0, '0, 1'b0},
            '{16'hFFFF, 1'b0, 1'b0, 2'd0, '0, 1'b0, '0, 1'b0},
            '{16'h0001, 1'b1, 1'b0, 2'd0, '0, 1'b0, '0, 1'b0},
            '{16'd7, 1'b0, 1'b1, 2'd0, '0, 1'b0, '0, 1'b0},
            '{16'd7, 1'b0, 1'b1, 2'd1, BASE_CODE + CODE_W'(7), 1'b0, '0, 1'b0},
            '{16'd7, 1'b1, 1'b1, 2'd1, '0, 1'b1, '0, 1'b0}
        };

        // Hold reset, then release it once
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Walk the directed table
        for (int k = 0; k < DIR_ROWS; k++) begin
            row       = dir_rows[k];
            w.symbol  = row.symbol;
            w.last_in = row.last_in;
            feed_symbol(w, row.typed, int'(row.n_exp),
                        '{code: row.c0, last_out: row.l0},
                        '{code: row.c1, last_out: row.l1});
        end

        // Random streams under each idling pattern; drain between phases
        for (int p = 0; p < 4; p++) begin
            send_idle_pct  = send_pcts[p];
            recv_stall_pct = recv_pcts[p];
            random_streams(200);
            i_in_valid <= 1'b0;
            while (pending_codes.size() != 0) @(posedge i_clk);
            @(posedge i_clk);
        end

        // Drain and let the block settle
        i_in_valid <= 1'b0;
        while (pending_codes.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (n_errors == 0 && pending_codes.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// File: word_lzw_encoder_top.f
+incdir+sv
sv/wlzw_pkg.sv
sv/wlzw_slot_ram.sv
sv/wlzw_out_fifo.sv
sv/word_lzw_encoder_top.sv
tb/word_lzw_encoder_top_test.sv
